// ===== src/numeric_type_coercion_top_defines.svh =====
// assertion macros for the numeric type coercion block
// used by numeric_type_coercion_top; expects aclk and aresetn in scope
`ifndef NUMERIC_TYPE_COERCION_TOP_DEFINES_SVH
`define NUMERIC_TYPE_COERCION_TOP_DEFINES_SVH

// condition implies consequence in the same cycle
`define NTC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define NTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ntc_pkg.sv =====
// shared types, codes and constants of the numeric type coercion block
// no dependencies
package ntc_pkg;

    // type codes
    localparam logic [4:0] TY_NOTHING  = 5'd0;
    localparam logic [4:0] TY_BOOL     = 5'd1;
    localparam logic [4:0] TY_DECIMAL  = 5'd2;
    localparam logic [4:0] TY_DOUBLE   = 5'd3;
    localparam logic [4:0] TY_FLOAT    = 5'd4;
    localparam logic [4:0] TY_INTEGER  = 5'd5;
    localparam logic [4:0] TY_NONPOS   = 5'd6;
    localparam logic [4:0] TY_NEG      = 5'd7;
    localparam logic [4:0] TY_LONG     = 5'd8;
    localparam logic [4:0] TY_INT      = 5'd9;
    localparam logic [4:0] TY_SHORT    = 5'd10;
    localparam logic [4:0] TY_BYTE     = 5'd11;
    localparam logic [4:0] TY_NONNEG   = 5'd12;
    localparam logic [4:0] TY_ULONG    = 5'd13;
    localparam logic [4:0] TY_UINT     = 5'd14;
    localparam logic [4:0] TY_USHORT   = 5'd15;
    localparam logic [4:0] TY_UBYTE    = 5'd16;
    localparam logic [4:0] TY_POSITIVE = 5'd17;
    localparam logic [4:0] TY_OTHER    = 5'd18;

    // status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_ROUND  = 3'd1;
    localparam logic [2:0] ST_RANGE  = 3'd2;
    localparam logic [2:0] ST_UNSUP  = 3'd3;
    localparam logic [2:0] ST_TRUNC  = 3'd4;
    localparam logic [2:0] ST_REDUCE = 3'd5;

    // largest integer magnitudes converted exactly to a float target
    localparam logic signed [63:0] DBL_INT_LIMIT = 64'sd9007199254740991;
    localparam logic signed [63:0] FLT_INT_LIMIT = 64'sd16777215;

    // normaliser result
    typedef struct packed {
        logic [63:0] norm;
        logic [5:0]  lz;
        logic        zero;
    } ntc_norm_t;

    // right alignment result with rounding information
    typedef struct packed {
        logic [52:0] ip;
        logic        guard;
        logic        sticky;
    } ntc_align_t;

    // byte size of each type
    function automatic logic [3:0] type_bytes(input logic [4:0] t);
        logic [3:0] nb;
        case (t)
            TY_BOOL, TY_BYTE, TY_UBYTE:   nb = 4'd1;
            TY_SHORT, TY_USHORT:          nb = 4'd2;
            TY_FLOAT, TY_INT, TY_UINT:    nb = 4'd4;
            TY_DECIMAL, TY_DOUBLE, TY_INTEGER, TY_NONPOS, TY_NEG, TY_LONG,
            TY_NONNEG, TY_ULONG, TY_POSITIVE: nb = 4'd8;
            default:                      nb = 4'd0;
        endcase
        return nb;
    endfunction

endpackage

// ===== src/ntc_norm.sv =====
// leading-zero normaliser for 64-bit magnitudes, six halving steps
// depends on ntc_pkg
module ntc_norm import ntc_pkg::*; (
    input  logic [63:0] val,
    output ntc_norm_t   res
);
    logic [63:0] x1, x2, x3, x4, x5, x6;
    logic [5:0]  lz;

    // shift by 32, 16, 8, 4, 2, 1 while the top part is empty
    assign lz[5] = (val[63:32] == 32'd0);
    assign x1    = lz[5] ? {val[31:0], 32'd0} : val;
    assign lz[4] = (x1[63:48] == 16'd0);
    assign x2    = lz[4] ? {x1[47:0], 16'd0} : x1;
    assign lz[3] = (x2[63:56] == 8'd0);
    assign x3    = lz[3] ? {x2[55:0], 8'd0} : x2;
    assign lz[2] = (x3[63:60] == 4'd0);
    assign x4    = lz[2] ? {x3[59:0], 4'd0} : x3;
    assign lz[1] = (x4[63:62] == 2'd0);
    assign x5    = lz[1] ? {x4[61:0], 2'd0} : x4;
    assign lz[0] = ~x5[63];
    assign x6    = lz[0] ? {x5[62:0], 1'b0} : x5;

    assign res.norm = x6;
    assign res.lz   = lz;
    assign res.zero = (val == 64'd0);
endmodule

// ===== src/ntc_align.sv =====
// right alignment of a 53-bit significand with guard and sticky bits
// depends on ntc_pkg
module ntc_align import ntc_pkg::*; (
    input  logic [52:0] sig,
    input  logic [5:0]  sh,
    output ntc_align_t  res
);
    logic [116:0] t;

    // integer part from bit 64 up, fraction below
    assign t          = {sig, 64'd0} >> sh;
    assign res.ip     = t[116:64];
    assign res.guard  = t[63];
    assign res.sticky = |t[62:0];
endmodule

// ===== src/ntc_core.sv =====
// conversion datapath: source decode, float/integer conversion, range checks
// depends on ntc_pkg, ntc_norm and ntc_align
module ntc_core import ntc_pkg::*; (
    input  logic [4:0]  in_type,
    input  logic [4:0]  out_type,
    input  logic [63:0] in_bits,
    input  logic        allow_round,
    input  logic        allow_truncate,
    input  logic        allow_reduce_precision,
    output logic [2:0]  status,
    output logic [63:0] out_bits,
    output logic [3:0]  out_bytes
);
    ntc_norm_t   nrm;
    ntc_align_t  aln;
    logic [63:0] norm_in;
    logic [52:0] aln_sig;
    logic [5:0]  aln_sh;

    logic        src_real;
    logic        rnd_eff;
    logic [63:0] wd;
    logic [63:0] d;
    logic        ds;
    logic [10:0] de;
    logic [51:0] dm;
    logic        d_nan;
    logic        d_big;
    logic [5:0]  sh_int;
    logic [5:0]  sh_nar;
    logic [10:0] ne;
    logic        rup;
    logic [63:0] rmag;
    logic [63:0] rv;
    logic [2:0]  rl_st;

    logic [2:0]  tl_st;
    logic [63:0] tl_v;
    logic [63:0] mag_in;
    logic [2:0]  lst;
    logic [63:0] lv;
    logic [2:0]  ust;
    logic [63:0] u;

    logic [63:0] i2d;
    logic [63:0] i2f;
    logic [63:0] nar;
    logic [30:0] nar_body;
    logic        nar_up;

    logic [2:0]  st;
    logic [63:0] res;
    logic [3:0]  nb;

    function automatic logic outside(input logic [63:0] x, input logic signed [63:0] lo,
                                     input logic signed [63:0] hi);
        return ($signed(x) < lo) || ($signed(x) > hi);
    endfunction

    // shared normaliser: float subnormal mantissa or integer magnitude
    assign norm_in = (in_type == TY_FLOAT) ? {41'd0, in_bits[22:0]} : mag_in;

    ntc_norm u_norm (
        .val (norm_in),
        .res (nrm)
    );

    // widen binary32 to binary64
    always_comb begin
        if (in_bits[30:23] == 8'hFF) begin
            wd = {in_bits[31], 11'h7FF,
                  (in_bits[22:0] != 23'd0) ? {1'b1, in_bits[21:0]} : 23'd0, 29'd0};
        end else if (in_bits[30:23] == 8'd0) begin
            wd = (in_bits[22:0] == 23'd0) ? {in_bits[31], 63'd0} :
                 {in_bits[31], 11'd937 - {5'd0, nrm.lz}, nrm.norm[62:11]};
        end else begin
            wd = {in_bits[31], {3'd0, in_bits[30:23]} + 11'd896, in_bits[22:0], 29'd0};
        end
    end

    // real source view
    assign src_real = (in_type == TY_DECIMAL) || (in_type == TY_DOUBLE) ||
                      (in_type == TY_FLOAT);
    assign d     = (in_type == TY_FLOAT) ? wd : in_bits;
    assign ds    = d[63];
    assign de    = d[62:52];
    assign dm    = d[51:0];
    assign d_nan = (de == 11'h7FF) && (dm != 52'd0);
    assign d_big = (in_type == TY_FLOAT) ? (de >= 11'd1047) : (de >= 11'd1076);
    assign ne    = in_bits[62:52];

    // alignment shift for real-to-integer and for float subnormal results
    always_comb begin
        if (de >= 11'd1076)      sh_int = 6'd0;
        else if (de <= 11'd1012) sh_int = 6'd63;
        else                     sh_int = 6'(11'd1075 - de);
        if (ne <= 11'd863)       sh_nar = 6'd63;
        else if (ne >= 11'd897)  sh_nar = 6'd0;
        else                     sh_nar = 6'(11'd926 - ne);
    end

    assign aln_sig = (out_type == TY_FLOAT) ? {ne != 11'd0, in_bits[51:0]} : {de != 11'd0, dm};
    assign aln_sh  = (out_type == TY_FLOAT) ? sh_nar : sh_int;

    ntc_align u_align (
        .sig (aln_sig),
        .sh  (aln_sh),
        .res (aln)
    );

    // rounding permission only for wide integer and boolean targets
    always_comb begin
        case (out_type)
            TY_BOOL, TY_INTEGER, TY_NONPOS, TY_NEG, TY_LONG, TY_NONNEG, TY_ULONG,
            TY_POSITIVE: rnd_eff = allow_round;
            default:     rnd_eff = 1'b0;
        endcase
    end

    // real to integer, nearest even
    assign rup  = aln.guard & (aln.sticky | aln.ip[0]);
    assign rmag = {11'd0, aln.ip} + {63'd0, rup};
    assign rv   = ds ? (64'd0 - rmag) : rmag;

    always_comb begin
        if (d_nan)
            rl_st = ST_RANGE;
        else if (!rnd_eff && !ds && (aln.guard | aln.sticky))
            rl_st = ST_ROUND;
        else if (d_big)
            rl_st = ST_RANGE;
        else
            rl_st = ST_OK;
    end

    // integer and boolean sources
    always_comb begin
        tl_st = ST_OK;
        tl_v  = in_bits;
        case (in_type)
            TY_BOOL:     tl_v = {63'd0, |in_bits[7:0]};
            TY_INTEGER, TY_NONPOS, TY_NEG, TY_LONG: tl_v = in_bits;
            TY_INT:      tl_v = {{32{in_bits[31]}}, in_bits[31:0]};
            TY_SHORT:    tl_v = {{48{in_bits[15]}}, in_bits[15:0]};
            TY_BYTE:     tl_v = {{56{in_bits[7]}}, in_bits[7:0]};
            TY_NONNEG, TY_ULONG, TY_POSITIVE: begin
                if (in_bits[63])
                    tl_st = ST_RANGE;
            end
            TY_UINT:     tl_v = {32'd0, in_bits[31:0]};
            TY_USHORT:   tl_v = {48'd0, in_bits[15:0]};
            TY_UBYTE:    tl_v = {56'd0, in_bits[7:0]};
            default:     tl_st = ST_UNSUP;
        endcase
    end

    assign mag_in = tl_v[63] ? (64'd0 - tl_v) : tl_v;
    assign lst    = src_real ? rl_st : tl_st;
    assign lv     = src_real ? rv : tl_v;

    // unsigned view of the source
    always_comb begin
        if ((in_type == TY_NONNEG) || (in_type == TY_ULONG) || (in_type == TY_POSITIVE)) begin
            ust = ST_OK;
            u   = in_bits;
        end else begin
            ust = (lst != ST_OK) ? lst : (lv[63] ? ST_RANGE : ST_OK);
            u   = lv;
        end
    end

    // integer to binary64 and binary32, exact within the limits
    assign i2d = nrm.zero ? 64'd0 :
                 {tl_v[63], 11'd1086 - {5'd0, nrm.lz}, nrm.norm[62:11]};
    assign i2f = nrm.zero ? 64'd0 :
                 {32'd0, tl_v[63], 8'd190 - {2'd0, nrm.lz}, nrm.norm[62:40]};

    // binary64 to binary32, nearest even, overflow to infinity
    always_comb begin
        if (ne >= 11'd897) begin
            nar_up   = in_bits[28] & ((|in_bits[27:0]) | in_bits[29]);
            nar_body = {8'(ne - 11'd896), in_bits[51:29]} + {30'd0, nar_up};
        end else begin
            nar_up   = aln.guard & (aln.sticky | aln.ip[0]);
            nar_body = {8'd0, aln.ip[22:0]} + {30'd0, nar_up};
        end
        if ((ne == 11'h7FF) && (in_bits[51:0] != 52'd0))
            nar = {32'd0, in_bits[63], 8'hFF, 1'b1, in_bits[50:29]};
        else if (ne >= 11'd1151)
            nar = {32'd0, in_bits[63], 8'hFF, 23'd0};
        else
            nar = {32'd0, in_bits[63], nar_body};
    end

    // target selection
    always_comb begin
        st  = ST_UNSUP;
        res = 64'd0;
        nb  = 4'd0;
        if (in_type == out_type) begin
            if (in_type < TY_OTHER) begin
                st = ST_OK;
                nb = type_bytes(in_type);
                case (nb)
                    4'd1:    res = {56'd0, in_bits[7:0]};
                    4'd2:    res = {48'd0, in_bits[15:0]};
                    4'd4:    res = {32'd0, in_bits[31:0]};
                    4'd8:    res = in_bits;
                    default: res = 64'd0;
                endcase
            end
        end else begin
            case (out_type)
                TY_BOOL: begin
                    st = lst;
                    if (lst == ST_OK) begin
                        if (!allow_truncate && (lv != 64'd0) && (lv != 64'd1)) begin
                            st = ST_TRUNC;
                        end else begin
                            res = {63'd0, lv != 64'd0};
                            nb  = 4'd1;
                        end
                    end
                end
                TY_DECIMAL, TY_DOUBLE: begin
                    nb = 4'd8;
                    if ((in_type == TY_DECIMAL) || (in_type == TY_DOUBLE)) begin
                        st  = ST_OK;
                        res = in_bits;
                    end else if (in_type == TY_FLOAT) begin
                        st  = ST_OK;
                        res = wd;
                    end else begin
                        st  = (lst == ST_OK && outside(lv, -DBL_INT_LIMIT, DBL_INT_LIMIT)) ?
                              ST_RANGE : lst;
                        res = i2d;
                    end
                end
                TY_FLOAT: begin
                    nb = 4'd4;
                    if ((in_type == TY_DECIMAL) || (in_type == TY_DOUBLE)) begin
                        st  = allow_reduce_precision ? ST_OK : ST_REDUCE;
                        res = nar;
                    end else begin
                        st  = (lst == ST_OK && outside(lv, -FLT_INT_LIMIT, FLT_INT_LIMIT)) ?
                              ST_RANGE : lst;
                        res = i2f;
                    end
                end
                TY_INTEGER, TY_NONPOS, TY_NEG, TY_LONG: begin
                    nb  = 4'd8;
                    st  = lst;
                    res = lv;
                    if ((lst == ST_OK) &&
                        (((out_type == TY_NONPOS) && ($signed(lv) > 64'sd0)) ||
                         ((out_type == TY_NEG) && ($signed(lv) >= 64'sd0))))
                        st = ST_RANGE;
                end
                TY_INT: begin
                    nb  = 4'd4;
                    st  = (lst == ST_OK && outside(lv, -64'sd2147483648, 64'sd2147483647)) ?
                          ST_RANGE : lst;
                    res = {32'd0, lv[31:0]};
                end
                TY_SHORT: begin
                    nb  = 4'd2;
                    st  = (lst == ST_OK && outside(lv, -64'sd32768, 64'sd32767)) ?
                          ST_RANGE : lst;
                    res = {48'd0, lv[15:0]};
                end
                TY_BYTE: begin
                    nb  = 4'd1;
                    st  = (lst == ST_OK && outside(lv, -64'sd128, 64'sd127)) ?
                          ST_RANGE : lst;
                    res = {56'd0, lv[7:0]};
                end
                TY_NONNEG, TY_ULONG, TY_POSITIVE: begin
                    nb  = 4'd8;
                    st  = (ust == ST_OK && out_type == TY_POSITIVE && u == 64'd0) ?
                          ST_RANGE : ust;
                    res = u;
                end
                TY_UINT: begin
                    nb  = 4'd4;
                    st  = (ust == ST_OK && u[63:32] != 32'd0) ? ST_RANGE : ust;
                    res = u;
                end
                TY_USHORT: begin
                    nb  = 4'd2;
                    st  = (ust == ST_OK && u[63:16] != 48'd0) ? ST_RANGE : ust;
                    res = u;
                end
                TY_UBYTE: begin
                    nb  = 4'd1;
                    st  = (ust == ST_OK && u[63:8] != 56'd0) ? ST_RANGE : ust;
                    res = u;
                end
                default: st = ST_UNSUP;
            endcase
        end
    end

    // failure clears value and size
    assign status    = st;
    assign out_bits  = (st == ST_OK) ? res : 64'd0;
    assign out_bytes = (st == ST_OK) ? nb : 4'd0;
endmodule

// ===== src/numeric_type_coercion_top.sv =====
// Path: an accepted input transaction passes the input register, the conversion logic
// and the result register; m_tvalid rises when the result register is loaded.
// Throughput: one transaction per cycle; each register stage moves on when the next one
// is empty or being emptied, so a held result stops input once the input register is full.
// Reset: aresetn (synchronous, active low) clears both stage valid flags.
`include "numeric_type_coercion_top_defines.svh"
module numeric_type_coercion_top import ntc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // in_bits[63:0], allow_round[64], allow_truncate[65], allow_reduce_precision[66]
    input  logic [71:0] s_tdata,
    // in_type[4:0], out_type[9:5]
    input  logic [9:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_bits[63:0], out_bytes[67:64]
    output logic [71:0] m_tdata,
    // status[2:0]
    output logic [2:0]  m_tuser
);
    logic        in_vld_reg, in_vld_next;
    logic [4:0]  in_type_reg;
    logic [4:0]  out_type_reg;
    logic [63:0] in_bits_reg;
    logic        rnd_reg, trn_reg, red_reg;
    logic        out_vld_reg, out_vld_next;
    logic [2:0]  out_status_reg;
    logic [63:0] out_bits_reg;
    logic [3:0]  out_bytes_reg;
    logic        out_adv;
    logic [2:0]  c_status;
    logic [63:0] c_bits;
    logic [3:0]  c_bytes;

    // stage handshake
    assign out_adv      = ~out_vld_reg | m_tready;
    assign s_tready     = ~in_vld_reg | out_adv;
    assign in_vld_next  = s_tready ? s_tvalid : in_vld_reg;
    assign out_vld_next = out_adv ? in_vld_reg : out_vld_reg;

    // valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_bits_reg  <= s_tdata[63:0];
            rnd_reg      <= s_tdata[64];
            trn_reg      <= s_tdata[65];
            red_reg      <= s_tdata[66];
            in_type_reg  <= s_tuser[4:0];
            out_type_reg <= s_tuser[9:5];
        end
    end

    ntc_core u_core (
        .in_type                (in_type_reg),
        .out_type               (out_type_reg),
        .in_bits                (in_bits_reg),
        .allow_round            (rnd_reg),
        .allow_truncate         (trn_reg),
        .allow_reduce_precision (red_reg),
        .status                 (c_status),
        .out_bits               (c_bits),
        .out_bytes              (c_bytes)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (out_adv && in_vld_reg) begin
            out_status_reg <= c_status;
            out_bits_reg   <= c_bits;
            out_bytes_reg  <= c_bytes;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'd0, out_bytes_reg, out_bits_reg};
    assign m_tuser  = out_status_reg;

    // checks on the conversion and the stage hand-over
    `NTC_ASSERT_NOW(a_fail_zero, m_tvalid && (out_status_reg != ST_OK), (out_bits_reg == 64'd0) && (out_bytes_reg == 4'd0), "failed conversion carries a value")
    `NTC_ASSERT_NOW(a_status_known, m_tvalid, out_status_reg <= ST_REDUCE, "status code out of set")
    `NTC_ASSERT_NOW(a_narrow_clean, m_tvalid && (out_bytes_reg == 4'd4), out_bits_reg[63:32] == 32'd0, "four-byte result has high bits set")
    `NTC_ASSERT_NEXT(a_stage_moves, in_vld_reg && !out_vld_reg, out_vld_reg, "item not moved to result stage")
endmodule
